### design/tdq_pkg.sv
// Shared types and constants for the tick delay queue scheduler.
// Used by the controller, the link store and the top level; no dependencies.
package tdq_pkg;

   localparam int ID_W   = 5;
   localparam int TIME_W = 31;
   localparam int LINK_W = 6;

   localparam int DEF_TASK_COUNT = 32;

   localparam logic [LINK_W-1:0] NULL_LINK = '1;
   localparam logic [TIME_W-1:0] TIME_MAX  = '1;

   typedef enum logic [1:0] {
      KIND_QUERY     = 2'd0,
      KIND_TICK      = 2'd1,
      KIND_DELAY_REL = 2'd2,
      KIND_DELAY_ABS = 2'd3
   } tdq_kind_type;

   // One read port and one shared write address for both memories.
   typedef struct packed {
      logic              rd_en;
      logic [LINK_W-1:0] rd_addr;
      logic              wake_we;
      logic              link_we;
      logic [LINK_W-1:0] wr_addr;
      logic [TIME_W-1:0] wake_data;
      logic [LINK_W-1:0] link_data;
   } tdq_mem_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] wake;
      logic [LINK_W-1:0] link;
   } tdq_mem_rsp_type;

endpackage

### design/tdq_store.sv
// Wake time and successor link memories of the waiting list.
// Depends on tdq_pkg; one registered read port, one write address.
module tdq_store
   import tdq_pkg::*;
#(
   parameter int TASK_COUNT = DEF_TASK_COUNT
) (
   input  logic            clock,
   input  tdq_mem_req_type mem_req,
   output tdq_mem_rsp_type mem_rsp
);

   localparam int AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   logic [TIME_W-1:0] wake_mem [TASK_COUNT];
   logic [LINK_W-1:0] link_mem [TASK_COUNT];
   tdq_mem_rsp_type   rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wake_we) begin
         wake_mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wake_data;
      end
      if (mem_req.link_we) begin
         link_mem[mem_req.wr_addr[AW-1:0]] <= mem_req.link_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff.wake <= wake_mem[mem_req.rd_addr[AW-1:0]];
         rd_data_ff.link <= link_mem[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign mem_rsp = rd_data_ff;

endmodule

### design/tdq_ctrl.sv
// Sequencer of the scheduler: time counter, list head, walk and release.
// Depends on tdq_pkg; drives the memories in tdq_store.
module tdq_ctrl
   import tdq_pkg::*;
#(
   parameter int TASK_COUNT = DEF_TASK_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [ID_W-1:0]   req_task_id,
   input  logic [TIME_W-1:0] req_ticks,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_target_task,
   output logic [TIME_W-1:0] rsp_current_time,
   output logic              rsp_last,
   output tdq_mem_req_type   mem_req,
   input  tdq_mem_rsp_type   mem_rsp
);

   localparam logic [LINK_W-1:0] TC_L = LINK_W'(TASK_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_INS_NODE,
      ST_INS_PREV,
      ST_TICK_REL,
      ST_TICK_LAST
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] when_ff, when_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] stop_ff, stop_in;
   logic [LINK_W-1:0] guard_ff, guard_in;
   logic              found_ff, found_in;
   logic              stopped_ff, stopped_in;
   logic [ID_W-1:0]   pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_task_ff, rsp_task_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic              rsp_last_ff, rsp_last_in;

   tdq_kind_type      kind;
   logic [TIME_W:0]   rel_sum;
   logic [TIME_W-1:0] rel_when;
   logic [TIME_W-1:0] now_inc;
   logic [LINK_W-1:0] guard_nx;
   logic [LINK_W-1:0] id_link;
   logic              head_ok;
   logic              wake_le_when;
   logic              wake_le_now;
   logic              walk_found;
   logic              tick_rel;

   assign kind         = tdq_kind_type'(req_kind);
   assign rel_sum      = {1'b0, req_ticks} + {1'b0, now_ff};
   assign rel_when     = rel_sum[TIME_W] ? TIME_MAX : rel_sum[TIME_W-1:0];
   assign now_inc      = (now_ff == TIME_MAX) ? now_ff : now_ff + 1'b1;
   assign guard_nx     = guard_ff + 1'b1;
   assign id_link      = {1'b0, id_ff};
   assign head_ok      = head_ff < TC_L;
   assign wake_le_when = mem_rsp.wake <= when_ff;
   assign wake_le_now  = mem_rsp.wake <= now_ff;
   assign walk_found   = found_ff | (cur_ff == id_link);
   assign tick_rel     = (count_ff != '0) && wake_le_now;

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      id_in        = id_ff;
      when_in      = when_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      stop_in      = stop_ff;
      guard_in     = guard_ff;
      found_in     = found_ff;
      stopped_in   = stopped_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_task_in  = rsp_task_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_last_in  = rsp_last_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               id_in = req_task_id;
               unique case (kind) inside
                  KIND_QUERY: begin
                     rsp_valid_in = 1'b1;
                     rsp_task_in  = req_task_id;
                     rsp_time_in  = now_ff;
                     rsp_last_in  = 1'b1;
                  end
                  KIND_TICK: begin
                     now_in  = now_inc;
                     pend_in = req_task_id;
                     if (head_ok && count_ff != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_ff;
                        cur_in          = head_ff;
                        state_in        = ST_TICK_REL;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_task_in  = req_task_id;
                        rsp_time_in  = now_inc;
                        rsp_last_in  = 1'b1;
                        if (!head_ok) begin
                           head_in  = NULL_LINK;
                           count_in = '0;
                        end
                     end
                  end
                  KIND_DELAY_REL, KIND_DELAY_ABS: begin
                     when_in  = (kind == KIND_DELAY_REL) ? rel_when : req_ticks;
                     state_in = ST_DECIDE;
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            if (when_ff <= now_ff || id_link >= TC_L) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = id_ff;
               rsp_time_in  = now_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               found_in   = 1'b0;
               stopped_in = 1'b0;
               prev_in    = NULL_LINK;
               guard_in   = '0;
               if (head_ok) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_ff;
                  cur_in          = head_ff;
                  state_in        = ST_WALK;
               end else begin
                  stop_in  = NULL_LINK;
                  state_in = ST_INS_NODE;
               end
            end
         end
         ST_WALK: begin
            // The whole list is walked: the duplicate check needs every entry,
            // while the insert point is fixed at the first later wake time.
            found_in = walk_found;
            if (!stopped_ff) begin
               if (wake_le_when) begin
                  prev_in = cur_ff;
               end else begin
                  stopped_in = 1'b1;
                  stop_in    = cur_ff;
               end
            end
            if (mem_rsp.link < TC_L && guard_nx < TC_L) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mem_rsp.link;
               cur_in          = mem_rsp.link;
               guard_in        = guard_nx;
            end else begin
               if (!stopped_ff && wake_le_when) begin
                  stop_in = mem_rsp.link;
               end
               state_in = walk_found ? ST_IDLE : ST_INS_NODE;
            end
         end
         ST_INS_NODE: begin
            mem_req.wake_we   = 1'b1;
            mem_req.link_we   = 1'b1;
            mem_req.wr_addr   = id_link;
            mem_req.wake_data = when_ff;
            mem_req.link_data = (stop_ff < TC_L) ? stop_ff : NULL_LINK;
            state_in          = ST_INS_PREV;
         end
         ST_INS_PREV: begin
            if (prev_ff < TC_L) begin
               mem_req.link_we   = 1'b1;
               mem_req.wr_addr   = prev_ff;
               mem_req.link_data = id_link;
            end else begin
               head_in = id_link;
            end
            count_in = count_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_TICK_REL: begin
            // The pending reply goes out once it is known whether another follows.
            rsp_valid_in = 1'b1;
            rsp_task_in  = pend_ff;
            rsp_time_in  = now_ff;
            rsp_last_in  = !tick_rel;
            if (tick_rel) begin
               head_in  = mem_rsp.link;
               count_in = count_ff - 1'b1;
               pend_in  = cur_ff[ID_W-1:0];
               if (mem_rsp.link < TC_L && count_ff != LINK_W'(1)) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = mem_rsp.link;
                  cur_in          = mem_rsp.link;
               end else begin
                  state_in = ST_TICK_LAST;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_LAST: begin
            rsp_valid_in = 1'b1;
            rsp_task_in  = pend_ff;
            rsp_time_in  = now_ff;
            rsp_last_in  = 1'b1;
            if (!head_ok) begin
               head_in  = NULL_LINK;
               count_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         head_ff      <= NULL_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff       <= id_in;
      when_ff     <= when_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      stop_ff     <= stop_in;
      guard_ff    <= guard_in;
      found_ff    <= found_in;
      stopped_ff  <= stopped_in;
      pend_ff     <= pend_in;
      rsp_task_ff <= rsp_task_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_task  = rsp_task_ff;
   assign rsp_current_time = rsp_time_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### design/tick_delay_queue_scheduler.sv
// Top level of the tick delay queue scheduler.
// Depends on tdq_pkg, tdq_store and tdq_ctrl.
//
//   Channel   Direction  Handshake              Payload
//   request   in         start high, busy low   req_kind, req_task_id, req_ticks
//   response  out        rsp_valid, one cycle   rsp_target_task, rsp_current_time,
//                                               rsp_last
//
// A time query answers in the cycle after it is taken and leaves the block idle.
// A tick with an empty queue answers in the same way; otherwise it reads the
// head and releases due tasks one by one in ST_TICK_REL, since each release waits
// on one registered read of the link memory. A delay that answers at once passes
// through ST_DECIDE first; otherwise it walks the queue at one entry per cycle
// and, unless the task already waits, writes it in ST_INS_NODE and ST_INS_PREV.
// Synchronous reset empties the queue by setting the head to the null marker and
// the count to zero; the memories need no clearing. The receiver cannot stall.
module tick_delay_queue_scheduler
   import tdq_pkg::*;
#(
   parameter int TASK_COUNT = DEF_TASK_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [ID_W-1:0]   req_task_id,
   input  logic [TIME_W-1:0] req_ticks,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_target_task,
   output logic [TIME_W-1:0] rsp_current_time,
   output logic              rsp_last
);

   // The waiting list lives in the store as a singly linked list sorted by
   // wake time; the controller holds the head, the count and the tick counter.
   tdq_mem_req_type mem_req;
   tdq_mem_rsp_type mem_rsp;

   tdq_store #(
      .TASK_COUNT(TASK_COUNT)
   ) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   tdq_ctrl #(
      .TASK_COUNT(TASK_COUNT)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_task_id      (req_task_id),
      .req_ticks        (req_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_target_task  (rsp_target_task),
      .rsp_current_time (rsp_current_time),
      .rsp_last         (rsp_last),
      .mem_req          (mem_req),
      .mem_rsp          (mem_rsp)
   );

endmodule
